FILE: src/spectral_noise_floor_tracker_unit_macros.svh
// ----------------------------------------------------------------------------
// Noise floor tracker assertion macros
// Concurrent check wrappers that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_NOISE_FLOOR_TRACKER_UNIT_MACROS_SVH
`define SPECTRAL_NOISE_FLOOR_TRACKER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SMFT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("smft: property violated");
`define SMFT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("smft: forbidden condition seen");
`else
`define SMFT_ASSERT(lbl, clk, rst, prop)
`define SMFT_NEVER(lbl, clk, rst, cond)
`endif
`endif

FILE: src/smft_pkg.sv
// ----------------------------------------------------------------------------
// Noise floor tracker package
// Shared types, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package smft_pkg;

   localparam logic [15:0] GAMMA    = 16'd65405;
   localparam logic [15:0] BETA_AT  = 16'd62915;
   localparam logic signed [12:0] MIN_RISE = 13'sd3277;
   localparam logic [39:0] FLT_MIN  = 40'd1;
   localparam logic [39:0] MAX40    = 40'hFF_FFFF_FFFF;
   localparam logic [16:0] ONE_Q16  = 17'h10000;

   localparam int NSTG = 10;

   localparam logic [2:0] CSR_LOW_XOVER  = 3'd0;
   localparam logic [2:0] CSR_MID_XOVER  = 3'd1;
   localparam logic [2:0] CSR_THR_ONE    = 3'd2;
   localparam logic [2:0] CSR_THR_TWO    = 3'd3;
   localparam logic [2:0] CSR_THR_THREE  = 3'd4;
   localparam logic [2:0] CSR_POWER_COEF = 3'd5;
   localparam logic [2:0] CSR_PROB_COEF  = 3'd6;
   localparam logic [2:0] CSR_NOISE_FLR  = 3'd7;

   typedef struct packed {
      logic [9:0]  lo_bin;
      logic [9:0]  mid_bin;
      logic [15:0] thr_one;
      logic [15:0] thr_two;
      logic [15:0] thr_three;
      logic [15:0] pcoef;
      logic [15:0] qcoef;
      logic [15:0] nfloor;
   } cfg_type;

   typedef struct packed {
      logic [39:0] smooth;
      logic [39:0] minimum;
      logic [15:0] prob;
      logic [39:0] noise;
   } state_word_type;

   typedef struct packed {
      logic        pass;
      logic [9:0]  k;
      logic [31:0] pw;
      logic [39:0] s_old;
      logic [39:0] m_old;
      logic [15:0] p_old;
      logic [39:0] n_old;
      logic [15:0] thr;
      logic [55:0] prod_a;
      logic [48:0] prod_b;
      logic [55:0] prod_beta;
      logic [55:0] prod_gamma;
      logic [39:0] s_new;
      logic [41:0] d;
      logic        lt;
      logic [54:0] dm;
      logic [39:0] m_new;
      logic [55:0] pt;
      logic [31:0] pp;
      logic        speech;
      logic [33:0] psum;
      logic [15:0] prob;
      logic [32:0] pa;
      logic [16:0] alpha;
      logic [56:0] pn_a;
      logic [48:0] pn_b;
      logic [39:0] n_new;
      logic [31:0] noise;
   } pipe_type;

endpackage

FILE: src/smft_state_mem.sv
// ----------------------------------------------------------------------------
// Noise floor tracker state memory
// Per-bin state store with registered read and a clearing sweep after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "spectral_noise_floor_tracker_unit_macros.svh"
module smft_state_mem
   import smft_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           rd_en,
   input  logic [AW-1:0]  rd_addr,
   output state_word_type rd_data,
   input  logic           wr_en,
   input  logic [AW-1:0]  wr_addr,
   input  state_word_type wr_data,
   output logic           busy
);

   state_word_type store_mem [DEPTH];
   state_word_type rd_ff;
   logic           busy_ff, busy_in;
   logic [AW-1:0]  clr_addr_ff, clr_addr_in;
   logic           we;
   logic [AW-1:0]  waddr;
   state_word_type wdata;
   state_word_type clr_word;

   assign clr_word = '{smooth: '0, minimum: FLT_MIN, prob: '0, noise: '0};

   // sweep one entry a cycle until the last one is written
   always_comb begin
      busy_in     = busy_ff;
      clr_addr_in = clr_addr_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign we    = busy_ff | wr_en;
   assign waddr = busy_ff ? clr_addr_ff : wr_addr;
   assign wdata = busy_ff ? clr_word : wr_data;

   always_ff @(posedge clock) begin
      if (we) begin
         store_mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;
   assign busy    = busy_ff;

   `SMFT_ASSERT(a_clear_steps, clock, reset, busy_ff && $past(busy_ff) && !$past(reset) |-> clr_addr_ff == $past(clr_addr_ff) + AW'(1))

endmodule

FILE: src/smft_pipe.sv
// ----------------------------------------------------------------------------
// Noise floor tracker pipeline
// Ten-stage datapath with per-stage valid, stall chain and bin interlock.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "spectral_noise_floor_tracker_unit_macros.svh"
module smft_pipe
   import smft_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [9:0]     in_k,
   input  logic [31:0]    in_pw,
   output logic           out_valid,
   input  logic           out_ready,
   output pipe_type       out_item,
   input  logic           mem_busy,
   output logic           rd_en,
   output logic [AW-1:0]  rd_addr,
   input  state_word_type rd_data,
   output logic           wr_en,
   output logic [AW-1:0]  wr_addr,
   output state_word_type wr_data
);

   localparam logic [10:0] DEPTH_L = 11'(DEPTH);

   pipe_type         stg_ff [1:NSTG];
   pipe_type         nxt    [1:NSTG];
   logic [NSTG:1]    vld_ff, vld_in;
   logic [NSTG:1]    rdy, adv;
   logic             in_pass, hazard, in_accept;

   function automatic pipe_type stage_fn(int i, pipe_type x, state_word_type rd,
                                         cfg_type c);
      pipe_type           y;
      logic [56:0]        t57;
      logic [40:0]        sb;
      logic signed [58:0] acc;
      logic [42:0]        mq;
      logic [16:0]        w17;
      logic [32:0]        spk;
      logic [17:0]        q18;
      logic [33:0]        t34;
      logic [17:0]        at;
      logic [57:0]        nsum;
      logic [41:0]        nq;
      y    = x;
      t57  = '0;
      sb   = '0;
      acc  = '0;
      mq   = '0;
      w17  = '0;
      spk  = '0;
      q18  = '0;
      t34  = '0;
      at   = '0;
      nsum = '0;
      nq   = '0;
      case (i)
         2: begin
            y.s_old = rd.smooth;
            y.m_old = rd.minimum;
            y.p_old = rd.prob;
            y.n_old = rd.noise;
            // high band wins over low band when the crossovers overlap
            if (x.k >= c.mid_bin) begin
               y.thr = c.thr_three;
            end else if (x.k <= c.lo_bin) begin
               y.thr = c.thr_one;
            end else begin
               y.thr = c.thr_two;
            end
            w17          = ONE_Q16 - {1'b0, c.pcoef};
            y.prod_a     = c.pcoef * rd.smooth;
            y.prod_b     = w17 * x.pw;
            y.prod_beta  = BETA_AT * rd.smooth;
            y.prod_gamma = GAMMA * rd.minimum;
         end
         3: begin
            t57     = {1'b0, x.prod_a} + {8'b0, x.prod_b} + 57'd32768;
            y.s_new = t57[55:16];
            t57     = {1'b0, x.prod_beta} + 57'd32768;
            sb      = t57[56:16];
            y.d     = {2'b00, y.s_new} - {1'b0, sb};
            y.lt    = x.m_old < y.s_new;
         end
         4: begin
            y.dm = $signed(x.d) * MIN_RISE;
         end
         5: begin
            acc = $signed({3'b000, x.prod_gamma}) + $signed({{4{x.dm[54]}}, x.dm})
                  + 59'sd32768;
            mq  = acc[58:16];
            if (!x.lt) begin
               y.m_new = x.s_new;
            end else if (acc[58]) begin
               y.m_new = '0;
            end else if (mq > {3'b000, MAX40}) begin
               y.m_new = MAX40;
            end else begin
               y.m_new = mq[39:0];
            end
         end
         6: begin
            y.pt = x.thr * x.m_new;
            y.pp = c.qcoef * x.p_old;
         end
         7: begin
            y.speech = {4'b0, x.s_new, 12'b0} > x.pt;
            w17      = ONE_Q16 - {1'b0, c.qcoef};
            spk      = 33'(w17) * 33'(16'hFFFF);
            y.psum   = {2'b00, x.pp} + (y.speech ? {1'b0, spk} : 34'd0) + 34'd32768;
         end
         8: begin
            q18    = x.psum[33:16];
            y.prob = (q18 > 18'd65535) ? 16'hFFFF : q18[15:0];
            w17    = ONE_Q16 - {1'b0, c.nfloor};
            y.pa   = w17 * y.prob;
         end
         9: begin
            t34     = {1'b0, x.pa} + 34'd32768;
            at      = {2'b00, c.nfloor} + t34[33:16];
            y.alpha = (at > 18'h10000) ? ONE_Q16 : at[16:0];
            w17     = ONE_Q16 - y.alpha;
            y.pn_a  = y.alpha * x.n_old;
            y.pn_b  = w17 * x.pw;
         end
         10: begin
            nsum    = {1'b0, x.pn_a} + {9'b0, x.pn_b} + 58'd32768;
            nq      = nsum[57:16];
            y.n_new = (nq > {2'b00, MAX40}) ? MAX40 : nq[39:0];
            y.noise = (y.n_new > 40'hFFFF_FFFF) ? 32'hFFFF_FFFF : y.n_new[31:0];
            if (x.pass) begin
               y.noise  = '0;
               y.speech = 1'b0;
               y.prob   = '0;
            end
         end
         default: begin
            y = x;
         end
      endcase
      return y;
   endfunction

   // bin zero and bins past the store bypass the state
   assign in_pass = (in_k == 10'd0) || ({1'b0, in_k} >= DEPTH_L);

   // hold a bin back while an earlier word of the same bin has not written back
   always_comb begin
      hazard = 1'b0;
      for (int i = 1; i < NSTG; i++) begin
         if (vld_ff[i] && !stg_ff[i].pass && (stg_ff[i].k == in_k)) begin
            hazard = 1'b1;
         end
      end
      if (in_pass) begin
         hazard = 1'b0;
      end
   end

   always_comb begin
      rdy[NSTG] = !vld_ff[NSTG] || out_ready;
      for (int i = NSTG - 1; i >= 1; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
   end

   assign in_ready  = rdy[1] && !mem_busy && !hazard;
   assign in_accept = in_valid && in_ready;

   always_comb begin
      adv[1] = in_accept;
      for (int i = 2; i <= NSTG; i++) begin
         adv[i] = vld_ff[i-1] && rdy[i];
      end
      for (int i = 1; i <= NSTG; i++) begin
         vld_in[i] = adv[i] || (vld_ff[i] && !rdy[i]);
      end
   end

   always_comb begin
      nxt[1]      = '0;
      nxt[1].pass = in_pass;
      nxt[1].k    = in_k;
      nxt[1].pw   = in_pw;
      for (int i = 2; i <= NSTG; i++) begin
         nxt[i] = stage_fn(i, stg_ff[i-1], rd_data, cfg);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 1; i <= NSTG; i++) begin
         if (adv[i]) begin
            stg_ff[i] <= nxt[i];
         end
      end
   end

   assign rd_en   = in_accept;
   assign rd_addr = in_k[AW-1:0];

   assign wr_en   = adv[NSTG] && !nxt[NSTG].pass;
   assign wr_addr = nxt[NSTG].k[AW-1:0];
   assign wr_data = '{smooth:  nxt[NSTG].s_new,
                      minimum: nxt[NSTG].m_new,
                      prob:    nxt[NSTG].prob,
                      noise:   nxt[NSTG].n_new};

   assign out_valid = vld_ff[NSTG];
   assign out_item  = stg_ff[NSTG];

   `SMFT_NEVER(a_no_raw_collision, clock, reset, wr_en && in_accept && !in_pass && (wr_addr == rd_addr))
   `SMFT_ASSERT(a_accept_lands, clock, reset, in_accept |=> vld_ff[1])
   `SMFT_NEVER(a_no_accept_clearing, clock, reset, in_accept && mem_busy)

endmodule

FILE: src/spectral_noise_floor_tracker_unit.sv
// ----------------------------------------------------------------------------
// Spectral noise floor tracker
// Per-bin noise estimate from a stream of power-spectrum bins.
// ----------------------------------------------------------------------------
// The block takes one spectrum bin word per clock and returns that bin's
// noise estimate, speech flag and smoothed presence probability, one result
// per clock while rsp_tready is high, in order. Sustained rate is one word
// per cycle as long as no word names a bin still in flight and responses
// are taken: such a word waits until the earlier word has written its state
// back. After reset the state memory is swept once, one entry a cycle;
// req_tready stays low during the sweep while register writes are taken
// as usual.
// Bin zero and bins at or above NUM_BINS return zero noise, flag and probability and leave state alone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module spectral_noise_floor_tracker_unit
   import smft_pkg::*;
#(
   parameter int NUM_BINS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // [9:0] bin_index, [41:10] bin_power, zero pad
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // [9:0] out_bin_index, [41:10] noise_power,
                                   // [42] speech_detected,
                                   // [58:43] presence_probability, zero pad
   // register write port
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   // the store never holds more than 1024 bins: the bin index is 10 bits wide
   localparam int DEPTH = (NUM_BINS < 1024) ? NUM_BINS : 1024;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cfg_type        cfg_ff, cfg_in;
   logic           mem_busy;
   logic           rd_en, wr_en;
   logic [AW-1:0]  rd_addr, wr_addr;
   state_word_type rd_data, wr_data;
   pipe_type       out_item;

   // register file: hold unless written, drop the upper bits of narrow fields
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_LOW_XOVER:  cfg_in.lo_bin    = csr_wdata[9:0];
            CSR_MID_XOVER:  cfg_in.mid_bin   = csr_wdata[9:0];
            CSR_THR_ONE:    cfg_in.thr_one   = csr_wdata;
            CSR_THR_TWO:    cfg_in.thr_two   = csr_wdata;
            CSR_THR_THREE:  cfg_in.thr_three = csr_wdata;
            CSR_POWER_COEF: cfg_in.pcoef     = csr_wdata;
            CSR_PROB_COEF:  cfg_in.qcoef     = csr_wdata;
            CSR_NOISE_FLR:  cfg_in.nfloor    = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{lo_bin: 10'd43, mid_bin: 10'd128, thr_one: 16'd8192,
                    thr_two: 16'd8192, thr_three: 16'd20480, pcoef: 16'd45875,
                    qcoef: 16'd13107, nfloor: 16'd55705};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // per-bin state: smoothed power, running minimum, probability, noise
   smft_state_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .busy    (mem_busy)
   );

   // read at accept, write back as the word enters the output register
   smft_pipe #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_k      (req_tdata[9:0]),
      .in_pw     (req_tdata[41:10]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item),
      .mem_busy  (mem_busy),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   assign rsp_tdata = {5'b0, out_item.prob, out_item.speech, out_item.noise, out_item.k};

endmodule
